// ===== hdl/iirdf1_pkg.sv =====
// Shared types and constants for the direct form I IIR filter.
// No dependencies; imported by the filter top level and its multiply-accumulate.
package iirdf1_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS   = 16;
    localparam int COEF_BITS     = 24;
    localparam int FRAC_SHIFT    = COEF_BITS - 4;
    localparam int ORDER_BITS    = 4;
    localparam int IDX_BITS      = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 4;

    // default for the top level parameter
    localparam int MAX_ORDER_DEF = 8;

    // reset value of both order registers
    localparam logic [ORDER_BITS-1:0] ORDER_RESET = 4'd2;

    // request operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // coefficient banks
    localparam logic SET_FF = 1'b0;
    localparam logic SET_FB = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_ORDER = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_ORDER = 1'b1;

    typedef struct packed {
        logic [1:0]                   op;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                         coef_set;
        logic [IDX_BITS-1:0]          coef_index;
        logic signed [COEF_BITS-1:0]  coef_value;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last;
    } t_out_req;

    // sequencer to multiply-accumulate control
    typedef struct packed {
        logic clear;
        logic tap_v;
        logic neg;
    } t_mac_ctl;

endpackage

// ===== hdl/iir_direct_form_one_filter.sv =====
// Direct form I IIR filter: sequencer, history and coefficient memories, output register.
// Depends on iirdf1_pkg, iirdf1_ram and iirdf1_mac.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------
//   in       | input     | i_in_valid / o_in_stall | i_in  (t_in_req)
//   out      | output    | o_out_valid / i_out_stall | o_out (t_out_req)
//   cfg      | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A sample request runs the filter step: history write, feedforward taps, feedback taps
// (N, M the clamped orders, one shared multiplier walks every tap), two drain states and
// rounding; the next request is taken only once the result is registered. A flush repeats
// the step N times; a coefficient write is done in idle. After reset a clearing pass
// over 2*(MAX_ORDER+1) addresses zeroes both memories while input stalls. Output stall
// holds the sequencer at rounding only, while a result still waits in the output register.
module iir_direct_form_one_filter #(
    parameter int MAX_ORDER = iirdf1_pkg::MAX_ORDER_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  iirdf1_pkg::t_in_req                    i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output iirdf1_pkg::t_out_req                   o_out,
    input  logic                                   i_cfg_we,
    input  logic [iirdf1_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [iirdf1_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import iirdf1_pkg::*;

    localparam int TAPS  = MAX_ORDER + 1;
    localparam int TAP_W = $clog2(TAPS);
    localparam int AW    = $clog2(2 * TAPS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_XWR,
        ST_FF,
        ST_FB,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_ROUND
    } t_state;

    t_state                        r_state;
    logic [ORDER_BITS-1:0]         r_pole;
    logic [ORDER_BITS-1:0]         r_zero;
    logic [TAP_W-1:0]              r_ptr;
    logic [TAP_W-1:0]              r_rd_ptr;
    logic [TAP_W-1:0]              r_tap;
    logic [TAP_W-1:0]              r_remain;
    logic [SAMPLE_BITS-1:0]        r_x;
    logic [AW-1:0]                 r_clr_addr;
    logic                          r_iss_v;
    logic                          r_iss_neg;
    logic                          r_out_valid;
    t_out_req                      r_out;

    logic [TAP_W-1:0]              ord_n;
    logic [TAP_W-1:0]              ord_m;
    logic [TAP_W-1:0]              ptr_next;
    logic [TAP_W-1:0]              ptr_dec;
    logic [TAP_W-1:0]              rd_dec;
    logic                          in_acc;
    logic                          fire;

    logic                          coef_we;
    logic [AW-1:0]                 coef_waddr;
    logic [COEF_BITS-1:0]          coef_wdata;
    logic [AW-1:0]                 coef_raddr;
    logic [COEF_BITS-1:0]          coef_rdata;
    logic                          hist_we;
    logic [AW-1:0]                 hist_waddr;
    logic [SAMPLE_BITS-1:0]        hist_wdata;
    logic [AW-1:0]                 hist_raddr;
    logic [SAMPLE_BITS-1:0]        hist_rdata;
    t_mac_ctl                      mac_ctl;
    logic signed [SAMPLE_BITS-1:0] mac_y;

    // orders above MAX_ORDER saturate
    assign ord_n = (int'(r_zero) > MAX_ORDER) ? TAP_W'(MAX_ORDER) : TAP_W'(r_zero);
    assign ord_m = (int'(r_pole) > MAX_ORDER) ? TAP_W'(MAX_ORDER) : TAP_W'(r_pole);

    // history rings: r_ptr marks the newest entry, older entries sit below it
    assign ptr_next = (r_ptr == TAP_W'(MAX_ORDER)) ? '0 : r_ptr + 1'b1;
    assign ptr_dec  = (r_ptr == '0) ? TAP_W'(MAX_ORDER) : r_ptr - 1'b1;
    assign rd_dec   = (r_rd_ptr == '0) ? TAP_W'(MAX_ORDER) : r_rd_ptr - 1'b1;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign fire        = (r_state == ST_ROUND) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // coefficient memory: b at 0..TAPS-1, a at TAPS..2*TAPS-1
    always_comb begin
        coef_we    = 1'b0;
        coef_waddr = r_clr_addr;
        coef_wdata = '0;
        if (r_state == ST_CLEAR) begin
            coef_we = 1'b1;
        end else if (in_acc && i_in.op == OP_COEF
                     && int'(i_in.coef_index) <= MAX_ORDER) begin
            coef_we    = 1'b1;
            coef_waddr = (i_in.coef_set == SET_FB)
                         ? AW'(TAPS) + AW'(i_in.coef_index)
                         : AW'(i_in.coef_index);
            coef_wdata = i_in.coef_value;
        end
    end

    // history memory: inputs at 0..TAPS-1, outputs at TAPS..2*TAPS-1
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = r_clr_addr;
        hist_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                hist_we = 1'b1;
            end
            ST_XWR: begin
                hist_we    = 1'b1;
                hist_waddr = AW'(ptr_next);
                hist_wdata = r_x;
            end
            ST_ROUND: begin
                hist_we    = fire;
                hist_waddr = AW'(TAPS) + AW'(r_ptr);
                hist_wdata = mac_y;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_state == ST_FB) begin
            coef_raddr = AW'(TAPS) + AW'(r_tap);
            hist_raddr = AW'(TAPS) + AW'(r_rd_ptr);
        end else begin
            coef_raddr = AW'(r_tap);
            hist_raddr = AW'(r_rd_ptr);
        end
    end

    assign mac_ctl = '{clear: (r_state == ST_XWR), tap_v: r_iss_v, neg: r_iss_neg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_ptr       <= '0;
            r_rd_ptr    <= '0;
            r_tap       <= '0;
            r_remain    <= '0;
            r_iss_v     <= 1'b0;
            r_iss_neg   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pole      <= ORDER_RESET;
            r_zero      <= ORDER_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POLE_ORDER: r_pole <= i_cfg_data;
                    CFG_ZERO_ORDER: r_zero <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_iss_v   <= 1'b0;
            r_iss_neg <= 1'b0;

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(2 * TAPS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_in.op)
                            OP_SAMPLE: begin
                                r_x      <= i_in.sample_in;
                                r_remain <= TAP_W'(1);
                                r_state  <= ST_XWR;
                            end
                            OP_FLUSH: begin
                                r_x      <= '0;
                                r_remain <= ord_n;
                                if (ord_n != '0) begin
                                    r_state <= ST_XWR;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_XWR: begin
                    r_ptr    <= ptr_next;
                    r_rd_ptr <= ptr_next;
                    r_tap    <= '0;
                    r_state  <= ST_FF;
                end
                ST_FF: begin
                    r_iss_v <= 1'b1;
                    if (r_tap == ord_n) begin
                        if (ord_m == '0) begin
                            r_state <= ST_DRAIN1;
                        end else begin
                            r_tap    <= TAP_W'(1);
                            r_rd_ptr <= ptr_dec;
                            r_state  <= ST_FB;
                        end
                    end else begin
                        r_tap    <= r_tap + 1'b1;
                        r_rd_ptr <= rd_dec;
                    end
                end
                ST_FB: begin
                    r_iss_v   <= 1'b1;
                    r_iss_neg <= 1'b1;
                    if (r_tap == ord_m) begin
                        r_state <= ST_DRAIN1;
                    end else begin
                        r_tap    <= r_tap + 1'b1;
                        r_rd_ptr <= rd_dec;
                    end
                end
                ST_DRAIN1: begin
                    r_state <= ST_DRAIN2;
                end
                ST_DRAIN2: begin
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    // hold until the output register frees up
                    if (fire) begin
                        r_out_valid      <= 1'b1;
                        r_out.sample_out <= mac_y;
                        r_out.last       <= (r_remain == TAP_W'(1));
                        if (r_remain == TAP_W'(1)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_remain <= r_remain - 1'b1;
                            r_state  <= ST_XWR;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    iirdf1_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (2 * TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    iirdf1_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (2 * TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    iirdf1_mac #(
        .MAX_ORDER (MAX_ORDER)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  (coef_rdata),
        .i_hist  (hist_rdata),
        .o_y     (mac_y)
    );

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_remain == TAP_W'(1)) |=> (o_out_valid && o_out.last))
        else $error("final result of a request lacks last");

    a_remain_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_XWR) |-> (r_remain != '0))
        else $error("filter step started with no result owed");

    a_issue_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_v |-> $past(r_state == ST_FF || r_state == ST_FB))
        else $error("tap issued outside the tap walk");

    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FF || r_state == ST_FB) |->
            (int'(r_rd_ptr) <= MAX_ORDER && int'(r_tap) <= MAX_ORDER))
        else $error("history ring pointer out of range");

endmodule

// ===== hdl/iirdf1_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module iirdf1_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 18
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/iirdf1_mac.sv =====
// Shared multiply-accumulate of the IIR filter, with round and saturate.
// Depends on iirdf1_pkg.
module iirdf1_mac #(
    parameter int MAX_ORDER = iirdf1_pkg::MAX_ORDER_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  iirdf1_pkg::t_mac_ctl                  i_ctl,
    input  logic [iirdf1_pkg::COEF_BITS-1:0]      i_coef,
    input  logic [iirdf1_pkg::SAMPLE_BITS-1:0]    i_hist,
    output logic signed [iirdf1_pkg::SAMPLE_BITS-1:0] o_y
);
    import iirdf1_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + $clog2(2 * MAX_ORDER + 1) + 1;
    localparam int ACC_BITS  = (SUM_BITS > 64) ? 64 : SUM_BITS;
    localparam int QW        = ACC_BITS - FRAC_SHIFT;

    localparam logic signed [ACC_BITS-1:0] HALF =
        {{(ACC_BITS - FRAC_SHIFT + 1){1'b0}}, {(FRAC_SHIFT - 1){1'b0}}} |
        (ACC_BITS'(1) << (FRAC_SHIFT - 1));
    localparam logic signed [QW-1:0] Q_MAX =
        {{(QW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = ~Q_MAX;

    logic                        r_prod_v;
    logic                        r_prod_neg;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  prod_ext;
    logic signed [ACC_BITS-1:0]  rnd;
    logic signed [QW-1:0]        q;

    assign prod_ext = ACC_BITS'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.tap_v;
        end
        r_prod_neg <= i_ctl.neg;
        r_prod     <= $signed(i_coef) * $signed(i_hist);
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            // feedback taps subtract
            r_acc <= r_prod_neg ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end
    end

    // round to nearest, ties up, then saturate
    assign rnd = r_acc + HALF;
    assign q   = rnd[ACC_BITS-1:FRAC_SHIFT];

    always_comb begin
        if (q > Q_MAX) begin
            o_y = Q_MAX[SAMPLE_BITS-1:0];
        end else if (q < Q_MIN) begin
            o_y = Q_MIN[SAMPLE_BITS-1:0];
        end else begin
            o_y = q[SAMPLE_BITS-1:0];
        end
    end

endmodule
